// File: src/iptcp_pkg.sv
`default_nettype none
package iptcp_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam logic [15:0] POS_LIMIT = 16'(MAX_PACKET_BYTES);

    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [6:0]  MIN_HDR_BYTES = 7'd20;
    localparam logic [15:0] MIN_PKT_BYTES = 16'd40;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
    localparam logic [2:0] ST_BAD_IPHDR = 3'd3;
    localparam logic [2:0] ST_BAD_TOTAL = 3'd4;
    localparam logic [2:0] ST_NOT_TCP   = 3'd5;
    localparam logic [2:0] ST_BAD_TCP   = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // result queue; depth must be a power of two, at least 2
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = FIFO_AW + 1;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] sequence_value;
        logic [31:0] acknowledgment_value;
        logic [5:0]  control_flags;
        logic [15:0] window_value;
        logic [15:0] payload_length;
    } t_result;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage
`default_nettype wire

// File: src/iptcp_ifs.sv
`default_nettype none
interface iptcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface iptcp_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] sequence_value;
    logic [31:0] acknowledgment_value;
    logic [5:0]  control_flags;
    logic [15:0] window_value;
    logic [15:0] payload_length;

    modport source (
        output valid, result_kind, payload_byte, status, source_address,
               destination_address, src_port, dst_port, sequence_value,
               acknowledgment_value, control_flags, window_value, payload_length,
        input  ready
    );
    modport sink (
        input  valid, result_kind, payload_byte, status, source_address,
               destination_address, src_port, dst_port, sequence_value,
               acknowledgment_value, control_flags, window_value, payload_length,
        output ready
    );
endinterface
`default_nettype wire

// File: src/iptcp_res_fifo.sv
`default_nettype none
module iptcp_res_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire iptcp_pkg::t_push  i_push,
    input  wire iptcp_pkg::t_result i_wr0,
    input  wire iptcp_pkg::t_result i_wr1,
    output logic                   o_room,
    iptcp_out_if.source            o_res
);

    iptcp_pkg::t_result r_mem [iptcp_pkg::FIFO_DEPTH];

    logic [iptcp_pkg::FIFO_AW-1:0] r_wr;
    logic [iptcp_pkg::FIFO_AW-1:0] r_rd;
    logic [iptcp_pkg::FIFO_CW-1:0] r_count;
    logic [iptcp_pkg::FIFO_CW-1:0] n_count;
    logic [iptcp_pkg::FIFO_CW-1:0] push_cnt;
    logic                          pop;
    iptcp_pkg::t_result            head;

    assign pop      = o_res.valid && o_res.ready;
    assign push_cnt = iptcp_pkg::FIFO_CW'(i_push.first) + iptcp_pkg::FIFO_CW'(i_push.second);
    assign n_count  = r_count + push_cnt - iptcp_pkg::FIFO_CW'(pop);
    assign o_room   = r_count <= iptcp_pkg::FIFO_CW'(iptcp_pkg::FIFO_DEPTH - 2);
    assign head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_wr0;
        end
        if (i_push.second) begin
            r_mem[r_wr + iptcp_pkg::FIFO_AW'(1)] <= i_wr1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + push_cnt[iptcp_pkg::FIFO_AW-1:0];
            r_rd    <= r_rd + iptcp_pkg::FIFO_AW'(pop);
            r_count <= n_count;
        end
    end

    assign o_res.valid                = r_count != '0;
    assign o_res.result_kind          = head.result_kind;
    assign o_res.payload_byte         = head.payload_byte;
    assign o_res.status               = head.status;
    assign o_res.source_address       = head.source_address;
    assign o_res.destination_address  = head.destination_address;
    assign o_res.src_port             = head.src_port;
    assign o_res.dst_port             = head.dst_port;
    assign o_res.sequence_value       = head.sequence_value;
    assign o_res.acknowledgment_value = head.acknowledgment_value;
    assign o_res.control_flags        = head.control_flags;
    assign o_res.window_value         = head.window_value;
    assign o_res.payload_length       = head.payload_length;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iptcp_pkg::FIFO_CW'(iptcp_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.second |-> i_push.first)
        else $error("second push without first");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.first |-> o_room)
        else $error("push into full queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("pointers disagree with empty count");

endmodule
`default_nettype wire

// File: src/ipv4_tcp_header_parser.sv
// Channel  Dir  Handshake     Beat
// i_pkt    in   valid/ready   one packet byte, last_byte on the final one
// o_res    out  valid/ready   payload byte result or end-of-packet summary
//
// One byte is taken per cycle while the queue has room; header capture and
// checks finish in that cycle. Results are registered in a four-entry queue
// and leave at most one per cycle; a final byte that also carries payload
// adds two. i_pkt.ready drops while fewer than two queue entries are free.
// Synchronous active-low reset clears the parser and empties the queue.
`default_nettype none
module ipv4_tcp_header_parser (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    iptcp_in_if.sink     i_pkt,
    iptcp_out_if.source  o_res
);

    logic [15:0] r_pos,   n_pos;
    logic [3:0]  r_ihl,   n_ihl;
    logic [3:0]  r_ver,   n_ver;
    logic [15:0] r_total, n_total;
    logic [7:0]  r_proto, n_proto;
    logic [3:0]  r_tcpw,  n_tcpw;
    logic [63:0] r_addr,  n_addr;
    logic [31:0] r_ports, n_ports;
    logic [63:0] r_seq,   n_seq;
    logic [21:0] r_fw,    n_fw;

    logic              acc;
    logic              live;
    logic              pay_hit;
    logic [7:0]        b;
    logic [5:0]        tcp_off;
    logic [5:0]        tcp_len;
    logic [6:0]        tcp_end;
    logic [6:0]        ip_min;
    logic [15:0]       rel;
    logic [2:0]        st;
    logic              room;
    iptcp_pkg::t_push  push;
    iptcp_pkg::t_result pay_res;
    iptcp_pkg::t_result sum_res;

    assign b           = i_pkt.data_byte;
    assign i_pkt.ready = room;
    assign acc         = i_pkt.valid && room;
    assign live        = r_pos < iptcp_pkg::POS_LIMIT;

    always_comb begin
        n_pos   = r_pos;
        n_ihl   = r_ihl;
        n_ver   = r_ver;
        n_total = r_total;
        n_proto = r_proto;
        n_tcpw  = r_tcpw;
        n_addr  = r_addr;
        n_ports = r_ports;
        n_seq   = r_seq;
        n_fw    = r_fw;
        pay_hit = 1'b0;
        if (live && r_pos == 16'd0) begin
            n_ver = b[7:4];
            n_ihl = b[3:0];
        end
        tcp_off = {n_ihl, 2'b00};
        rel     = r_pos - {10'd0, tcp_off};
        if (live) begin
            if (r_pos == 16'd2 || r_pos == 16'd3) begin
                n_total = {r_total[7:0], b};
            end
            if (r_pos == 16'd9) begin
                n_proto = b;
            end
            if (r_pos >= 16'd12 && r_pos < 16'd20) begin
                n_addr = {r_addr[55:0], b};
            end
            if (r_pos >= {10'd0, tcp_off}) begin
                if (rel < 16'd4) begin
                    n_ports = {r_ports[23:0], b};
                end else if (rel < 16'd12) begin
                    n_seq = {r_seq[55:0], b};
                end else if (rel == 16'd12) begin
                    n_tcpw = b[7:4];
                end else if (rel == 16'd13) begin
                    n_fw[21:16] = b[5:0];
                end else if (rel < 16'd16) begin
                    n_fw[15:0] = {r_fw[7:0], b};
                end
            end
            n_pos = r_pos + 16'd1;
        end
        tcp_len = {n_tcpw, 2'b00};
        tcp_end = {1'b0, tcp_off} + {1'b0, tcp_len};
        if (live && r_pos >= 16'd3 && r_pos >= 16'({1'b0, tcp_off} + 7'd12)
                && r_pos >= {9'd0, tcp_end} && r_pos < n_total) begin
            pay_hit = 1'b1;
        end
    end

    always_comb begin
        ip_min = {1'b0, tcp_off} + iptcp_pkg::MIN_HDR_BYTES;
        if (n_pos < iptcp_pkg::MIN_PKT_BYTES) begin
            st = iptcp_pkg::ST_SHORT;
        end else if (n_ver != iptcp_pkg::IP_VERSION) begin
            st = iptcp_pkg::ST_NOT_IPV4;
        end else if ({1'b0, tcp_off} < iptcp_pkg::MIN_HDR_BYTES
                || n_pos < {9'd0, ip_min}) begin
            st = iptcp_pkg::ST_BAD_IPHDR;
        end else if (n_total < {9'd0, ip_min} || n_total > n_pos) begin
            st = iptcp_pkg::ST_BAD_TOTAL;
        end else if (n_proto != iptcp_pkg::PROTO_TCP) begin
            st = iptcp_pkg::ST_NOT_TCP;
        end else if ({1'b0, tcp_len} < iptcp_pkg::MIN_HDR_BYTES
                || {9'd0, tcp_end} > n_total) begin
            st = iptcp_pkg::ST_BAD_TCP;
        end else begin
            st = iptcp_pkg::ST_OK;
        end
    end

    always_comb begin
        pay_res              = '0;
        pay_res.result_kind  = iptcp_pkg::KIND_PAYLOAD;
        pay_res.payload_byte = b;

        sum_res             = '0;
        sum_res.result_kind = iptcp_pkg::KIND_SUMMARY;
        sum_res.status      = st;
        if (st == iptcp_pkg::ST_OK) begin
            sum_res.source_address       = n_addr[63:32];
            sum_res.destination_address  = n_addr[31:0];
            sum_res.src_port             = n_ports[31:16];
            sum_res.dst_port             = n_ports[15:0];
            sum_res.sequence_value       = n_seq[63:32];
            sum_res.acknowledgment_value = n_seq[31:0];
            sum_res.control_flags        = n_fw[21:16];
            sum_res.window_value         = n_fw[15:0];
            sum_res.payload_length       = n_total - {9'd0, tcp_end};
        end

        push.first  = acc && (pay_hit || i_pkt.last_byte);
        push.second = acc && pay_hit && i_pkt.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && i_pkt.last_byte)) begin
            r_pos   <= '0;
            r_ihl   <= '0;
            r_ver   <= '0;
            r_total <= '0;
            r_proto <= '0;
            r_tcpw  <= '0;
            r_addr  <= '0;
            r_ports <= '0;
            r_seq   <= '0;
            r_fw    <= '0;
        end else if (acc) begin
            r_pos   <= n_pos;
            r_ihl   <= n_ihl;
            r_ver   <= n_ver;
            r_total <= n_total;
            r_proto <= n_proto;
            r_tcpw  <= n_tcpw;
            r_addr  <= n_addr;
            r_ports <= n_ports;
            r_seq   <= n_seq;
            r_fw    <= n_fw;
        end
    end

    iptcp_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wr0   (pay_hit ? pay_res : sum_res),
        .i_wr1   (sum_res),
        .o_room  (room),
        .o_res   (o_res)
    );

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_pkt.last_byte) |=> (r_pos == 16'd0 && r_tcpw == 4'd0))
        else $error("packet state not cleared after final byte");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_pkt.last_byte && live) |=> (r_pos == $past(r_pos) + 16'd1))
        else $error("byte position did not advance");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!acc) |=> $stable(r_pos))
        else $error("byte position moved without a beat");

    a_no_payload_past_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pay_hit |-> (live && r_pos < n_total))
        else $error("payload emitted outside packet window");

endmodule
`default_nettype wire

// File: bench/tb_ipv4_tcp_header_parser.sv
`default_nettype none
module tb_ipv4_tcp_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BEATS = 2000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef enum int unsigned {
        BREAK_VERSION,
        BREAK_IHL,
        BREAK_PROTOCOL,
        BREAK_THL,
        BREAK_TOTAL,
        BREAK_LENGTH
    } t_break;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iptcp_in_if  pkt_if ();
    iptcp_out_if res_if ();

    ipv4_tcp_header_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if),
        .o_res   (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_beat              wire_bytes[$];
    iptcp_pkg::t_result due_results[$];
    logic [7:0]         frame[$];
    t_beat              beat;
    iptcp_pkg::t_result want;
    logic               byte_taken = 1'b0;
    logic [31:0]        cycles = '0;
    logic               calm;
    int unsigned        mismatches = 0;

    // header parser state
    int unsigned at_pos;
    int unsigned ihl_words;
    int unsigned ver_nibble;
    int unsigned tot_len;
    int unsigned proto_byte;
    int unsigned thl_words;
    logic [63:0] addr_pair;
    logic [31:0] port_pair;
    logic [63:0] seq_ack;
    logic [21:0] flags_win;

    assign calm = (cycles[10:8] == 3'd2);

    function automatic void clear_parse_state();
        at_pos     = 0;
        ihl_words  = 0;
        ver_nibble = 0;
        tot_len    = 0;
        proto_byte = 0;
        thl_words  = 0;
        addr_pair  = '0;
        port_pair  = '0;
        seq_ack    = '0;
        flags_win  = '0;
    endfunction

    function automatic logic [2:0] header_status(input int unsigned size);
        int unsigned ip_len;
        int unsigned tcp_len;
        ip_len  = ihl_words * 4;
        tcp_len = thl_words * 4;
        if (size < 40) return iptcp_pkg::ST_SHORT;
        if (ver_nibble != 4) return iptcp_pkg::ST_NOT_IPV4;
        if (ip_len < 20 || size < ip_len + 20) return iptcp_pkg::ST_BAD_IPHDR;
        if (tot_len < ip_len + 20 || tot_len > size) return iptcp_pkg::ST_BAD_TOTAL;
        if (proto_byte != 6) return iptcp_pkg::ST_NOT_TCP;
        if (tcp_len < 20 || ip_len + tcp_len > tot_len) return iptcp_pkg::ST_BAD_TCP;
        return iptcp_pkg::ST_OK;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        int unsigned        tcp_off;
        int unsigned        tcp_end;
        int unsigned        rel;
        iptcp_pkg::t_result r;
        if (at_pos < iptcp_pkg::MAX_PACKET_BYTES) begin
            if (at_pos == 0) begin
                ver_nibble = 32'(b[7:4]);
                ihl_words  = 32'(b[3:0]);
            end
            if (at_pos == 2 || at_pos == 3) tot_len = ((tot_len << 8) | 32'(b)) & 32'hffff;
            if (at_pos == 9) proto_byte = 32'(b);
            if (at_pos >= 12 && at_pos < 20) addr_pair = {addr_pair[55:0], b};
            tcp_off = ihl_words * 4;
            if (at_pos >= tcp_off) begin
                rel = at_pos - tcp_off;
                if (rel < 4) port_pair = {port_pair[23:0], b};
                else if (rel < 12) seq_ack = {seq_ack[55:0], b};
                else if (rel == 12) thl_words = 32'(b[7:4]);
                else if (rel == 13) flags_win[21:16] = b[5:0];
                else if (rel < 16) flags_win[15:0] = {flags_win[7:0], b};
            end
            tcp_end = tcp_off + thl_words * 4;
            if (at_pos >= 3 && at_pos >= tcp_off + 12 && at_pos >= tcp_end
                    && at_pos < tot_len) begin
                r = '0;
                r.result_kind  = iptcp_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
                due_results.insert(due_results.size(), r);
            end
            at_pos++;
        end
        if (last) begin
            r = '0;
            r.result_kind = iptcp_pkg::KIND_SUMMARY;
            r.status      = header_status(at_pos);
            if (r.status == iptcp_pkg::ST_OK) begin
                r.source_address       = addr_pair[63:32];
                r.destination_address  = addr_pair[31:0];
                r.src_port             = port_pair[31:16];
                r.dst_port             = port_pair[15:0];
                r.sequence_value       = seq_ack[63:32];
                r.acknowledgment_value = seq_ack[31:0];
                r.control_flags        = flags_win[21:16];
                r.window_value         = flags_win[15:0];
                r.payload_length       = 16'(tot_len - ihl_words * 4 - thl_words * 4);
            end
            due_results.insert(due_results.size(), r);
            clear_parse_state();
        end
    endfunction

    function automatic void build_frame(input int unsigned ihl, input int unsigned thl,
            input int unsigned pay);
        int unsigned n;
        int unsigned tot;
        tot = ihl * 4 + thl * 4 + pay;
        n   = (tot == 0) ? 1 : tot;
        frame.delete();
        repeat (n) frame.insert(frame.size(), 8'($urandom));
        frame[0] = {iptcp_pkg::IP_VERSION, 4'(ihl)};
        if (n > 3) begin
            frame[2] = 8'(tot >> 8);
            frame[3] = 8'(tot);
        end
        if (n > 9) frame[9] = iptcp_pkg::PROTO_TCP;
        if (ihl * 4 + 12 < n) frame[ihl * 4 + 12] = {4'(thl), 4'($urandom)};
    endfunction

    function automatic void queue_frame();
        t_beat bt;
        foreach (frame[i]) begin
            bt.data = frame[i];
            bt.last = (i == frame.size() - 1);
            wire_bytes.insert(wire_bytes.size(), bt);
        end
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
            input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            if (mismatches < 60)
                $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pkt_if.valid <= 1'b0;
            res_if.ready <= 1'b0;
        end else begin
            if (!pkt_if.valid || byte_taken) begin
                if (wire_bytes.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
                    beat = wire_bytes.pop_front();
                    pkt_if.valid     <= 1'b1;
                    pkt_if.data_byte <= beat.data;
                    pkt_if.last_byte <= beat.last;
                end else begin
                    pkt_if.valid <= 1'b0;
                end
            end
            res_if.ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        cycles     <= cycles + 1;
        byte_taken <= pkt_if.valid && pkt_if.ready;
        if (i_rst_n && pkt_if.valid && pkt_if.ready)
            parse_byte(pkt_if.data_byte, pkt_if.last_byte);
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_results.size() == 0) begin
                if (mismatches < 60)
                    $display("%0t: unexpected result, expected none actual kind %0d byte %0h",
                        $time, res_if.result_kind, res_if.payload_byte);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                compare_field("result_kind", 32'(want.result_kind),
                    32'(res_if.result_kind));
                compare_field("payload_byte", 32'(want.payload_byte),
                    32'(res_if.payload_byte));
                compare_field("status", 32'(want.status), 32'(res_if.status));
                compare_field("source_address", want.source_address,
                    res_if.source_address);
                compare_field("destination_address", want.destination_address,
                    res_if.destination_address);
                compare_field("src_port", 32'(want.src_port), 32'(res_if.src_port));
                compare_field("dst_port", 32'(want.dst_port), 32'(res_if.dst_port));
                compare_field("sequence_value", want.sequence_value,
                    res_if.sequence_value);
                compare_field("acknowledgment_value", want.acknowledgment_value,
                    res_if.acknowledgment_value);
                compare_field("control_flags", 32'(want.control_flags),
                    32'(res_if.control_flags));
                compare_field("window_value", 32'(want.window_value),
                    32'(res_if.window_value));
                compare_field("payload_length", 32'(want.payload_length),
                    32'(res_if.payload_length));
            end
        end
    end

    initial begin
        #30_000_000;
        $display("tb_ipv4_tcp_header_parser: errors");
        $finish;
    end

    initial begin
        int unsigned random_count;
        int unsigned ihl;
        int unsigned thl;
        int unsigned pick;
        int unsigned tot;
        t_break      flaw;

        pkt_if.valid     = 1'b0;
        pkt_if.data_byte = '0;
        pkt_if.last_byte = 1'b0;
        res_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        clear_parse_state();

        frame.delete();
        frame.insert(frame.size(), 8'h00);
        queue_frame();

        build_frame(5, 5, 0);
        for (int i = 12; i < 40; i++) frame[i] = 8'hff;
        frame[32] = 8'h5f;
        queue_frame();

        build_frame(5, 5, 0);
        for (int i = 12; i < 40; i++) frame[i] = 8'h00;
        frame[32] = 8'h50;
        queue_frame();

        build_frame(15, 15, 3);
        queue_frame();

        random_count = 0;
        while (random_count < RANDOM_BEATS) begin
            pick = $urandom_range(99);
            ihl  = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
            thl  = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
            build_frame(ihl, thl, $urandom_range(40));
            if (pick < 60) begin
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(6, 1)) frame.insert(frame.size(), 8'($urandom));
            end else if (pick < 90) begin
                flaw = t_break'($urandom_range(5));
                case (flaw)
                    BREAK_VERSION: begin
                        frame[0] = {4'($urandom), frame[0][3:0]};
                    end
                    BREAK_IHL: begin
                        frame[0] = {frame[0][7:4], 4'($urandom_range(4))};
                    end
                    BREAK_PROTOCOL: begin
                        frame[9] = 8'($urandom);
                    end
                    BREAK_THL: begin
                        frame[ihl * 4 + 12] = {4'($urandom_range(4)), frame[ihl * 4 + 12][3:0]};
                    end
                    BREAK_TOTAL: begin
                        tot = $urandom_range(frame.size() + 20);
                        frame[2] = 8'(tot >> 8);
                        frame[3] = 8'(tot);
                    end
                    BREAK_LENGTH: begin
                        tot = $urandom_range(frame.size() - 1, 1);
                        while (frame.size() > tot) void'(frame.pop_back());
                    end
                    default: ;
                endcase
            end else begin
                frame.delete();
                repeat ($urandom_range(80, 1)) frame.insert(frame.size(), 8'($urandom));
            end
            random_count += frame.size();
            queue_frame();
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (wire_bytes.size() != 0 || pkt_if.valid) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_ipv4_tcp_header_parser: clean");
        end else begin
            $display("tb_ipv4_tcp_header_parser: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
src/iptcp_pkg.sv
src/iptcp_ifs.sv
src/iptcp_res_fifo.sv
src/ipv4_tcp_header_parser.sv
bench/tb_ipv4_tcp_header_parser.sv
